// ----- rtl/core/pit_pkg.sv -----
`default_nettype none

package pit_pkg;

   // request kinds carried in req_tuser
   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2
   } op_type;

   // register selects
   typedef enum logic [2:0] {
      SEL_MODULE  = 3'd0,
      SEL_LOAD    = 3'd1,
      SEL_COUNT   = 3'd2,
      SEL_CONTROL = 3'd3,
      SEL_FLAG    = 3'd4
   } sel_type;

   localparam int DATA_W   = 32;
   localparam int OUT_CH_W = 2;   // channels visible in irq_lines / expired

   // register bit positions
   localparam int MOD_OFF_BIT    = 0;
   localparam int MOD_FREEZE_BIT = 1;
   localparam int CTL_EN_BIT     = 0;
   localparam int CTL_IRQ_BIT    = 1;
   localparam int FLAG_CLR_BIT   = 0;

   // request payload, last field in the lowest bits
   typedef struct packed {
      logic [2:0]        pad;
      logic              debug_halt;
      logic [DATA_W-1:0] write_data;
      logic [2:0]        reg_sel;
      logic              channel;
   } req_item_type;

   // response payload, last field in the lowest bits
   typedef struct packed {
      logic [3:0]          pad;
      logic [OUT_CH_W-1:0] expired;
      logic [OUT_CH_W-1:0] irq_lines;
      logic [DATA_W-1:0]   read_data;
   } rsp_item_type;

endpackage

`default_nettype wire

// ----- rtl/core/periodic_interrupt_timer_top.sv -----
`default_nettype none

// Channel   Direction  Handshake             Payload
// request   in         req_tvalid/req_tready req_tuser: op; req_tdata: channel, reg_sel,
//                                            write_data, debug_halt
// response  out        rsp_tvalid/rsp_tready rsp_tdata: read_data, irq_lines, expired
//
// One request per cycle sustained while responses are taken; a request is held in the
// request register, then its response in the response register, which drives
// rsp_tvalid and rsp_tdata.
// The whole register update of a request is one combinational pass between the two.
// Synchronous active-high reset: all timer state cleared, module held off.
// When rsp_tready is low the response register holds, one more request parks in the
// request register and req_tready then drops until the response is taken.

module periodic_interrupt_timer_top #(
   parameter int NUM_CHANNELS = 2
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [1:0]  req_tuser,   // [1:0] op
   input  wire  [39:0] req_tdata,   // [0] channel, [3:1] reg_sel, [35:4] write_data,
                                    // [36] debug_halt, [39:37] zero
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata    // [31:0] read_data, [33:32] irq_lines,
                                    // [35:34] expired, [39:36] zero
);
   import pit_pkg::*;

   // request stage
   logic          req_valid_ff;
   op_type        op_ff;
   req_item_type  item_ff;
   logic          advance;

   // timer state
   logic [NUM_CHANNELS-1:0][DATA_W-1:0] load_ff, load_in;
   logic [NUM_CHANNELS-1:0][DATA_W-1:0] count_ff, count_in;
   logic [NUM_CHANNELS-1:0]             enable_ff, enable_in;
   logic [NUM_CHANNELS-1:0]             irq_en_ff, irq_en_in;
   logic [NUM_CHANNELS-1:0]             flag_ff, flag_in;
   logic                                module_off_ff, module_off_in;
   logic                                freeze_ff, freeze_in;

   // datapath
   logic [NUM_CHANNELS-1:0] hit;
   logic [NUM_CHANNELS-1:0] fired;
   logic [NUM_CHANNELS-1:0] irq_all;
   logic                    run;
   logic [DATA_W-1:0]       rd_data;
   sel_type                 sel;
   rsp_item_type            rsp_in;

   // response stage
   logic          rsp_valid_ff;
   rsp_item_type  rsp_ff;

   // the request register moves on whenever the response register is free or draining
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         op_ff   <= op_type'(req_tuser);
         item_ff <= req_item_type'(req_tdata);
      end
   end

   assign sel = sel_type'(item_ff.reg_sel);
   // a tick counts only while the module is on and not frozen by a debug halt
   assign run = !module_off_ff && !(freeze_ff && item_ff.debug_halt);

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         hit[c] = ({1'b0, item_ff.channel} == 2'(c));
      end
   end

   // single-pass register update
   always_comb begin
      load_in       = load_ff;
      count_in      = count_ff;
      enable_in     = enable_ff;
      irq_en_in     = irq_en_ff;
      flag_in       = flag_ff;
      module_off_in = module_off_ff;
      freeze_in     = freeze_ff;
      fired         = '0;
      rd_data       = '0;
      unique case (op_ff)
         OP_TICK: begin
            if (run) begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (enable_ff[c]) begin
                     if (count_ff[c] == '0) begin
                        // period is load + 1 ticks
                        count_in[c] = load_ff[c];
                        flag_in[c]  = 1'b1;
                        fired[c]    = 1'b1;
                     end else begin
                        count_in[c] = count_ff[c] - DATA_W'(1);
                     end
                  end
               end
            end
         end
         OP_READ: begin
            if (sel == SEL_MODULE) begin
               rd_data[MOD_OFF_BIT]    = module_off_ff;
               rd_data[MOD_FREEZE_BIT] = freeze_ff;
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (hit[c]) begin
                  unique case (sel)
                     SEL_LOAD:  rd_data = load_ff[c];
                     SEL_COUNT: rd_data = count_ff[c];
                     SEL_CONTROL: begin
                        rd_data[CTL_EN_BIT]  = enable_ff[c];
                        rd_data[CTL_IRQ_BIT] = irq_en_ff[c];
                     end
                     SEL_FLAG: rd_data[FLAG_CLR_BIT] = flag_ff[c];
                     default: ;
                  endcase
               end
            end
         end
         OP_WRITE: begin
            if (sel == SEL_MODULE) begin
               module_off_in = item_ff.write_data[MOD_OFF_BIT];
               freeze_in     = item_ff.write_data[MOD_FREEZE_BIT];
            end
            for (int c = 0; c < NUM_CHANNELS; c++) begin
               if (hit[c]) begin
                  unique case (sel)
                     SEL_LOAD: load_in[c] = item_ff.write_data;
                     SEL_CONTROL: begin
                        // rising enable loads the count
                        if (item_ff.write_data[CTL_EN_BIT] && !enable_ff[c]) begin
                           count_in[c] = load_ff[c];
                        end
                        enable_in[c] = item_ff.write_data[CTL_EN_BIT];
                        irq_en_in[c] = item_ff.write_data[CTL_IRQ_BIT];
                     end
                     SEL_FLAG: begin
                        if (item_ff.write_data[FLAG_CLR_BIT]) begin
                           flag_in[c] = 1'b0;
                        end
                     end
                     default: ;   // count is read only
                  endcase
               end
            end
         end
         default: ;
      endcase
   end

   assign irq_all = flag_in & irq_en_in;

   // only the channels that fit the 2-bit fields are reported
   always_comb begin
      rsp_in           = '0;
      rsp_in.read_data = rd_data;
      rsp_in.irq_lines = OUT_CH_W'(irq_all);
      rsp_in.expired   = OUT_CH_W'(fired);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff       <= '0;
         count_ff      <= '0;
         enable_ff     <= '0;
         irq_en_ff     <= '0;
         flag_ff       <= '0;
         module_off_ff <= 1'b1;
         freeze_ff     <= 1'b0;
      end else if (advance) begin
         load_ff       <= load_in;
         count_ff      <= count_in;
         enable_ff     <= enable_in;
         irq_en_ff     <= irq_en_in;
         flag_ff       <= flag_in;
         module_off_ff <= module_off_in;
         freeze_ff     <= freeze_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

`ifndef SYNTHESIS
   // only ticks report reloads
   a_expire_on_tick: assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff != OP_TICK) |-> (fired == '0))
      else $error("reload reported outside a tick");

   // a stopped module leaves every count untouched
   a_off_holds: assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff == OP_TICK) && !run |-> (count_in == count_ff) && (fired == '0))
      else $error("count moved while stopped");

   // a parked request is never dropped
   a_park_kept: assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(item_ff))
      else $error("parked request lost");

   // a reload always leaves the flag set
   a_fire_sets_flag: assert property (@(posedge clock) disable iff (reset)
      advance |-> ((fired & ~flag_in) == '0))
      else $error("reload without flag");
`endif

endmodule

`default_nettype wire
